### rtl/sod_pkg.sv
// Shared types and constants for the Strahler order and drop accumulator.
// Used by sod_stat_acc and strahler_order_drop_accumulator_core; no dependencies.
package sod_pkg;

  localparam int ORDER_W = 4;
  localparam int ELEV_W  = 32;
  localparam int SUM_W   = 48;
  localparam int SQ_W    = 63;
  localparam int CNT_W32 = 32;
  localparam int LEN_W   = 48;
  localparam int STEP_W  = 17;

  localparam logic REQ_NEIGHBOR = 1'b0;
  localparam logic REQ_FINISH   = 1'b1;

  localparam logic [STEP_W-1:0]  STEP_ORTHO  = 17'd65536;
  localparam logic [STEP_W-1:0]  STEP_DIAG   = 17'd92682;
  localparam logic [ORDER_W-1:0] ORDER_MAX   = 4'd15;
  localparam logic [SQ_W-1:0]    SQ_MAX      = {SQ_W{1'b1}};
  localparam logic [63:0]        SQ_ROOT_MAX = 64'd3037000499;
  localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};

  typedef struct packed {
    logic                      req_type;
    logic [ORDER_W-1:0]        order_in;
    logic signed [ELEV_W-1:0]  elevation;
    logic                      is_diagonal;
  } item_t;

  typedef struct packed {
    logic [ORDER_W-1:0]        order_out;
    logic signed [ELEV_W-1:0]  elev_out;
    logic signed [SUM_W-1:0]   first_drop_sum;
    logic [SQ_W-1:0]           first_drop_sumsq;
    logic [CNT_W32-1:0]        first_count;
    logic signed [SUM_W-1:0]   higher_drop_sum;
    logic [SQ_W-1:0]           higher_drop_sumsq;
    logic [CNT_W32-1:0]        higher_count;
    logic [LEN_W-1:0]          stream_length;
  } result_t;

endpackage

### rtl/strahler_order_drop_accumulator_core.sv
// Top level of the Strahler order and segment-drop accumulator.
// Depends on sod_pkg and sod_stat_acc.
//
// Usage: the item channel (item_valid, item_stall, item) carries one record
// per transfer. A neighbour record (req_type 0) of nonzero order is buffered,
// updates the running order and adds 1 or root 2 to the stream length; it
// produces no result. Records of order zero, and records beyond MAX_INFLOW
// for the current cell, are dropped. A finish record (req_type 1) carries the
// cell elevation and produces one result transfer on the result channel
// (result_valid, result_stall, result). With fewer than two inflows the block
// goes straight to the done step and stalls the item channel there. At a
// junction the sequencer walks the buffered inflows: an inflow that keeps
// the new order is only fetched, one that ends a segment takes three steps
// (drop, square on the shared multiplier, accumulate), and then the result
// register is loaded. The result register holds its value while
// result_stall is high; neighbour records keep being taken meanwhile, but a
// finish that ends its walk waits until the previous result has been taken.
// Reset clears the cell state, all sums, counts and the stream length, and
// empties the result register; the inflow buffer is not cleared.
module strahler_order_drop_accumulator_core import sod_pkg::*; #(
  parameter int MAX_INFLOW = 8,
  parameter int ELEV_BITS  = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CNT_W  = $clog2(MAX_INFLOW + 1);
  localparam int IDX_W  = (MAX_INFLOW > 1) ? $clog2(MAX_INFLOW) : 1;
  localparam int DROP_W = ELEV_BITS + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_ACCUM  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;

  // Inflow buffer: order and stream-start elevation of each accepted inflow.
  logic [ORDER_W-1:0]          buf_order [MAX_INFLOW];
  logic signed [ELEV_BITS-1:0] buf_elev  [MAX_INFLOW];

  logic [CNT_W-1:0]   inflow_count;
  logic [ORDER_W-1:0] running_order;
  logic [ORDER_W-1:0] running_max;
  logic [LEN_W-1:0]   length;

  // Walk registers.
  logic [IDX_W-1:0]            k;
  logic signed [ELEV_BITS-1:0] cell_elev;
  logic signed [ELEV_BITS-1:0] eout;
  logic [ORDER_W-1:0]          oout;
  logic signed [DROP_W-1:0]    drop;
  logic [DROP_W-1:0]           mag;
  logic                        first_sel;
  logic [SQ_W-1:0]             sq;

  logic signed [SUM_W-1:0] first_sum, higher_sum;
  logic [SQ_W-1:0]         first_sumsq, higher_sumsq;
  logic [CNT_W32-1:0]      first_cnt, higher_cnt;

  logic                        item_fire;
  logic                        take_neighbor;
  logic                        take_finish;
  logic signed [ELEV_BITS-1:0] item_elev;
  logic [STEP_W-1:0]           step;
  logic [LEN_W:0]              length_wide;
  logic [ORDER_W-1:0]          k_order;
  logic signed [ELEV_BITS-1:0] k_elev;
  logic signed [DROP_W-1:0]    drop_next;
  logic                        last_entry;
  logic [2*ELEV_BITS-1:0]      product;
  logic                        result_free;

  assign item_stall    = (state != S_IDLE);
  assign item_fire     = item_valid && !item_stall;
  assign take_neighbor = item_fire && (item.req_type == REQ_NEIGHBOR) &&
                         (item.order_in != '0) && (inflow_count < CNT_W'(MAX_INFLOW));
  assign take_finish   = item_fire && (item.req_type == REQ_FINISH);
  assign item_elev     = item.elevation[ELEV_BITS-1:0];
  assign step          = item.is_diagonal ? STEP_DIAG : STEP_ORTHO;
  assign length_wide   = {1'b0, length} + (LEN_W+1)'(step);

  assign k_order    = buf_order[k];
  assign k_elev     = buf_elev[k];
  assign drop_next  = DROP_W'(k_elev) - DROP_W'(cell_elev);
  assign last_entry = (CNT_W'(k) + CNT_W'(1)) == inflow_count;
  assign product    = mag[ELEV_BITS-1:0] * mag[ELEV_BITS-1:0];
  assign result_free = !result_valid || !result_stall;

  // Buffer write; entries at or above inflow_count are never read.
  always_ff @(posedge clk) begin
    if (take_neighbor) begin
      buf_order[inflow_count[IDX_W-1:0]] <= item.order_in;
      buf_elev[inflow_count[IDX_W-1:0]]  <= item_elev;
    end
  end

  // Sequencer and cell state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      inflow_count  <= '0;
      running_order <= ORDER_W'(1);
      running_max   <= '0;
      length        <= '0;
      k             <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take_neighbor) begin
            inflow_count <= inflow_count + CNT_W'(1);
            if (item.order_in > running_max) begin
              running_max   <= item.order_in;
              running_order <= item.order_in;
            end else if (item.order_in == running_max) begin
              running_order <= (running_max < ORDER_MAX) ? running_max + ORDER_W'(1)
                                                         : ORDER_MAX;
            end
            length <= length_wide[LEN_W] ? LEN_MAX : length_wide[LEN_W-1:0];
          end else if (take_finish) begin
            k     <= '0;
            state <= (inflow_count >= CNT_W'(2)) ? S_FETCH : S_DONE;
          end
        end
        S_FETCH: begin
          if (k_order < oout) begin
            state <= S_SQUARE;
          end else if (last_entry) begin
            state <= S_DONE;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_SQUARE: begin
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          if (last_entry) begin
            state <= S_DONE;
          end else begin
            k     <= k + IDX_W'(1);
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          if (result_free) begin
            inflow_count  <= '0;
            running_order <= ORDER_W'(1);
            running_max   <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Walk datapath. The downstream elevation starts as the cell elevation, or
  // the single inflow's, and the last inflow that keeps the order overrides it.
  always_ff @(posedge clk) begin
    if (take_finish) begin
      cell_elev <= item_elev;
      oout      <= running_order;
      eout      <= (inflow_count == CNT_W'(1)) ? buf_elev[0] : item_elev;
    end
    if (state == S_FETCH) begin
      if (k_order < oout) begin
        drop      <= drop_next;
        mag       <= drop_next[DROP_W-1] ? DROP_W'(-drop_next) : DROP_W'(drop_next);
        first_sel <= (k_order == ORDER_W'(1));
      end else begin
        eout <= k_elev;
      end
    end
    if (state == S_SQUARE) begin
      sq <= (64'(mag) > SQ_ROOT_MAX) ? SQ_MAX : SQ_W'(product);
    end
  end

  sod_stat_acc #(.DROP_W(DROP_W)) u_first (
    .clk   (clk),
    .rst   (rst),
    .en    ((state == S_ACCUM) && first_sel),
    .drop  (drop),
    .sq    (sq),
    .sum   (first_sum),
    .sumsq (first_sumsq),
    .count (first_cnt)
  );

  sod_stat_acc #(.DROP_W(DROP_W)) u_higher (
    .clk   (clk),
    .rst   (rst),
    .en    ((state == S_ACCUM) && !first_sel),
    .drop  (drop),
    .sq    (sq),
    .sum   (higher_sum),
    .sumsq (higher_sumsq),
    .count (higher_cnt)
  );

  // Result register: loaded from a snapshot of the statistics at the end of a walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_DONE) && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && result_free) begin
      result.order_out         <= oout;
      result.elev_out          <= ELEV_W'(eout);
      result.first_drop_sum    <= first_sum;
      result.first_drop_sumsq  <= first_sumsq;
      result.first_count       <= first_cnt;
      result.higher_drop_sum   <= higher_sum;
      result.higher_drop_sumsq <= higher_sumsq;
      result.higher_count      <= higher_cnt;
      result.stream_length     <= length;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    inflow_count <= CNT_W'(MAX_INFLOW))
    else $error("inflow count above buffer depth");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    take_finish |=> (state != S_IDLE))
    else $error("finish transfer did not start a walk");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (CNT_W'(k) < inflow_count))
    else $error("walk index beyond buffered inflows");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done step");

  a_order_max: assert property (@(posedge clk) disable iff (rst)
    (inflow_count != '0) |-> ((running_order >= running_max) && (running_order != '0)))
    else $error("running order below running maximum");
`endif

endmodule

### rtl/sod_stat_acc.sv
// Saturating drop statistics: running sum, sum of squares and segment count.
// Depends on sod_pkg for the accumulator widths.
module sod_stat_acc import sod_pkg::*; #(
  parameter int DROP_W = 33
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic signed [DROP_W-1:0] drop,
  input  logic [SQ_W-1:0]          sq,
  output logic signed [SUM_W-1:0]  sum,
  output logic [SQ_W-1:0]          sumsq,
  output logic [CNT_W32-1:0]       count
);

  logic signed [SUM_W:0] sum_wide;
  logic [SQ_W:0]         sumsq_wide;
  logic signed [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0]       sumsq_next;

  always_comb begin
    sum_wide   = (SUM_W+1)'(sum) + (SUM_W+1)'(drop);
    sumsq_wide = {1'b0, sumsq} + {1'b0, sq};
    // A sign change between the two top bits means the sum left the 48-bit range.
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
    sumsq_next = sumsq_wide[SQ_W] ? SQ_MAX : sumsq_wide[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sumsq <= '0;
      count <= '0;
    end else if (en) begin
      sum   <= sum_next;
      sumsq <= sumsq_next;
      if (count != {CNT_W32{1'b1}}) begin
        count <= count + CNT_W32'(1);
      end
    end
  end

endmodule
